// ===== rtl/ihrc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package ihrc_pkg;

   // Operation codes carried in the request word
   typedef enum logic [1:0] {
      OP_CLEAR  = 2'd0,
      OP_INSERT = 2'd1,
      OP_LOOKUP = 2'd2,
      OP_QUERY  = 2'd3
   } op_type;

   localparam logic [0:0] STATUS_DONE = 1'b0;
   localparam logic [0:0] STATUS_FULL = 1'b1;

   typedef struct packed {
      op_type      op;
      logic [23:0] prefix;
      logic [7:0]  range_low;
      logic [7:0]  range_high;
      logic [31:0] site_id;
      logic [31:0] address;
   } req_type;

   typedef struct packed {
      logic [0:0]  status;
      logic        hit;
      logic [31:0] found_id;
   } rsp_type;

   // One stored rule
   typedef struct packed {
      logic [23:0] prefix;
      logic [7:0]  low;
      logic [7:0]  high;
      logic [31:0] id;
   } rule_type;

   // What the controller asks the datapath to load into the result register
   typedef enum logic [2:0] {
      RES_HOLD  = 3'd0,
      RES_DONE  = 3'd1,
      RES_FULL  = 3'd2,
      RES_MATCH = 3'd3,
      RES_MISS  = 3'd4
   } res_kind_type;

   typedef struct packed {
      logic         load;
      logic         clear;
      logic         write;
      logic         scan_start;
      logic         scan_run;
      res_kind_type res_kind;
   } ctrl_cmd_type;

   typedef struct packed {
      op_type op;
      logic   full;
      logic   empty;
      logic   match;
      logic   scan_end;
   } dp_status_type;

endpackage

`default_nettype wire

// ===== rtl/ip_host_range_classifier.sv =====
`timescale 1ns / 1ps
`default_nettype none

// IPv4 host-range classifier. Holds up to TABLE_DEPTH rules, each a 24-bit
// network prefix, an inclusive host-octet range and a 32-bit site id, kept in
// insertion order in a single-port-read rule memory. A request word carries one
// of four operations: clear, insert, look up an address, or query whether a
// prefix is present; every request yields exactly one result word. Lookup
// returns the id of the first rule, in insertion order, whose prefix equals
// address[31:8] and whose range holds address[7:0]; a prefix query reports only
// whether any rule carries the prefix. An insert into a full table is refused
// with status 1 and leaves the table alone. Rules with low > high are stored
// and count for prefix queries but never match a lookup. Requests are handled
// one at a time: clear, insert and any request on an empty table raise the
// result straight from the decode state; a lookup or query on a non-empty
// table first scans the rules in insertion order, one memory read per cycle,
// and stops early when a rule matches. A new request is taken only after the
// result has been taken and the block is back in idle.
// A result waits in its output register until taken. No clearing pass is
// needed after reset: the table is empty because the rule count resets to 0.

module ip_host_range_classifier #(
   parameter int TABLE_DEPTH = 64
) (
   input  wire                clock,
   input  wire                reset,
   input  wire                req_valid,
   output logic               req_ready,
   input  ihrc_pkg::req_type  req_word,
   output logic               rsp_valid,
   input  wire                rsp_ready,
   output ihrc_pkg::rsp_type  rsp_word
);

   // Command and status between sequencer and rule datapath
   ihrc_pkg::ctrl_cmd_type  cmd;
   ihrc_pkg::dp_status_type status;

   // Sequencer: accept, decode, drive the scan, hold the result
   ihrc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .status    (status)
   );

   // Datapath: rule memory, rule count, scan index, compare, result register
   ihrc_dp #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_dp (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .status   (status),
      .req_word (req_word),
      .rsp_word (rsp_word)
   );

endmodule

`default_nettype wire

// ===== rtl/ihrc_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ihrc_dp #(
   parameter int TABLE_DEPTH = 64
) (
   input  wire                    clock,
   input  wire                    reset,
   input  ihrc_pkg::ctrl_cmd_type cmd,
   output ihrc_pkg::dp_status_type status,
   input  ihrc_pkg::req_type      req_word,
   output ihrc_pkg::rsp_type      rsp_word
);

   localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(TABLE_DEPTH);

   ihrc_pkg::rule_type rule_mem [TABLE_DEPTH];

   ihrc_pkg::req_type  req_ff;
   ihrc_pkg::rsp_type  rsp_ff;
   ihrc_pkg::rule_type rd_ff;
   logic [CNT_W-1:0]   count_ff;
   logic [IDX_W-1:0]   idx_ff;
   logic               issue_done_ff;
   logic               rd_valid_ff;
   logic               rd_last_ff;

   logic               idx_last;
   logic               net_hit;
   logic               host_hit;
   logic               rule_hit;
   ihrc_pkg::rule_type wr_rule;

   assign idx_last = (CNT_W'(idx_ff) == (count_ff - CNT_W'(1)));

   assign net_hit  = (rd_ff.prefix == req_ff.address[31:8]);
   assign host_hit = (rd_ff.low <= req_ff.address[7:0]) && (req_ff.address[7:0] <= rd_ff.high);
   assign rule_hit = (req_ff.op == ihrc_pkg::OP_LOOKUP) ? (net_hit && host_hit)
                                                        : (rd_ff.prefix == req_ff.prefix);

   assign wr_rule = '{prefix: req_ff.prefix, low: req_ff.range_low,
                      high: req_ff.range_high, id: req_ff.site_id};

   assign status.op       = req_ff.op;
   assign status.full     = (count_ff == FULL_COUNT);
   assign status.empty    = (count_ff == '0);
   assign status.match    = rd_valid_ff && rule_hit;
   assign status.scan_end = rd_valid_ff && rd_last_ff;

   assign rsp_word = rsp_ff;

   // Rule memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (cmd.write) begin
         rule_mem[count_ff[IDX_W-1:0]] <= wr_rule;
      end
      if (cmd.scan_run && !issue_done_ff) begin
         rd_ff <= rule_mem[idx_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         idx_ff        <= '0;
         issue_done_ff <= 1'b0;
         rd_valid_ff   <= 1'b0;
         rd_last_ff    <= 1'b0;
      end else begin
         if (cmd.clear) begin
            count_ff <= '0;
         end else if (cmd.write) begin
            count_ff <= count_ff + CNT_W'(1);
         end

         if (cmd.scan_start) begin
            idx_ff        <= '0;
            issue_done_ff <= 1'b0;
            rd_valid_ff   <= 1'b0;
            rd_last_ff    <= 1'b0;
         end else if (cmd.scan_run) begin
            if (!issue_done_ff) begin
               idx_ff        <= idx_ff + IDX_W'(1);
               issue_done_ff <= idx_last;
               rd_valid_ff   <= 1'b1;
               rd_last_ff    <= idx_last;
            end else begin
               rd_valid_ff <= 1'b0;
            end
         end
      end
   end

   // Request and result payload
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff <= req_word;
      end
      case (cmd.res_kind)
         ihrc_pkg::RES_DONE: begin
            rsp_ff <= '{status: ihrc_pkg::STATUS_DONE, hit: 1'b0, found_id: 32'd0};
         end
         ihrc_pkg::RES_FULL: begin
            rsp_ff <= '{status: ihrc_pkg::STATUS_FULL, hit: 1'b0, found_id: 32'd0};
         end
         ihrc_pkg::RES_MATCH: begin
            rsp_ff <= '{status: ihrc_pkg::STATUS_DONE, hit: 1'b1,
                        found_id: (req_ff.op == ihrc_pkg::OP_LOOKUP) ? rd_ff.id : 32'd0};
         end
         ihrc_pkg::RES_MISS: begin
            rsp_ff <= '{status: ihrc_pkg::STATUS_DONE, hit: 1'b0, found_id: 32'd0};
         end
         default: begin
            rsp_ff <= rsp_ff;
         end
      endcase
   end

`ifndef SYNTHESIS
   a_no_write_when_full: assert property (@(posedge clock) disable iff (reset)
      cmd.write |-> !status.full)
      else $error("rule written into a full table");

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_COUNT)
      else $error("rule count beyond table depth");

   a_write_grows_count: assert property (@(posedge clock) disable iff (reset)
      (cmd.write && !cmd.clear) |=> (count_ff == $past(count_ff) + CNT_W'(1)))
      else $error("insert did not advance rule count");
`endif

endmodule

`default_nettype wire

// ===== rtl/ihrc_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ihrc_ctrl (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     req_valid,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  wire                     rsp_ready,
   output ihrc_pkg::ctrl_cmd_type  cmd,
   input  ihrc_pkg::dp_status_type status
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DECODE,
      ST_SCAN,
      ST_RESP
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      req_ready_ff;
   logic      rsp_valid_ff;

   assign req_ready = req_ready_ff;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd          = '{load: 1'b0, clear: 1'b0, write: 1'b0, scan_start: 1'b0,
                       scan_run: 1'b0, res_kind: ihrc_pkg::RES_HOLD};
      state_in     = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid && req_ready_ff) begin
               cmd.load = 1'b1;
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            unique case (status.op)
               ihrc_pkg::OP_CLEAR: begin
                  cmd.clear    = 1'b1;
                  cmd.res_kind = ihrc_pkg::RES_DONE;
                  state_in     = ST_RESP;
               end
               ihrc_pkg::OP_INSERT: begin
                  if (status.full) begin
                     cmd.res_kind = ihrc_pkg::RES_FULL;
                  end else begin
                     cmd.write    = 1'b1;
                     cmd.res_kind = ihrc_pkg::RES_DONE;
                  end
                  state_in = ST_RESP;
               end
               default: begin
                  if (status.empty) begin
                     cmd.res_kind = ihrc_pkg::RES_MISS;
                     state_in     = ST_RESP;
                  end else begin
                     cmd.scan_start = 1'b1;
                     state_in       = ST_SCAN;
                  end
               end
            endcase
         end
         ST_SCAN: begin
            cmd.scan_run = 1'b1;
            priority if (status.match) begin
               cmd.res_kind = ihrc_pkg::RES_MATCH;
               state_in     = ST_RESP;
            end else if (status.scan_end) begin
               cmd.res_kind = ihrc_pkg::RES_MISS;
               state_in     = ST_RESP;
            end else begin
               // keep scanning
               state_in = ST_SCAN;
            end
         end
         ST_RESP: begin
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         req_ready_ff <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         req_ready_ff <= (state_in == ST_IDLE);
         rsp_valid_ff <= (state_in == ST_RESP);
      end
   end

`ifndef SYNTHESIS
   a_one_side_busy: assert property (@(posedge clock) disable iff (reset)
      !(req_ready_ff && rsp_valid_ff))
      else $error("accepting a word while a result is pending");

   a_accept_closes: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready_ff) |=> !req_ready_ff)
      else $error("ready stayed high after accepting a word");

   a_result_reopens: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ready) |=> (req_ready_ff && !rsp_valid_ff))
      else $error("block did not return to idle after delivering a result");

   a_one_command: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load, cmd.clear, cmd.write, cmd.scan_start}))
      else $error("conflicting datapath commands");
`endif

endmodule

`default_nettype wire
